@@ rtl/core/dsq_pkg.sv @@
`timescale 1ns / 1ps

package dsq_pkg;

  localparam logic [7:0] DASH = 8'd45;

  typedef enum logic [2:0] {
    OP_ENQ        = 3'd0,
    OP_ENQ_OVWR   = 3'd1,
    OP_DEQ        = 3'd2,
    OP_BAL_ENQ    = 3'd3,
    OP_BAL_DEQ    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } lane_ctl_t;

endpackage

@@ rtl/core/dsq_cell.sv @@
`timescale 1ns / 1ps

module dsq_cell
  import dsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift,
  input  logic       load,
  input  logic [7:0] item,
  input  logic [7:0] next_data,
  output logic [7:0] data
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = item;
    end else if (shift) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= DASH;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data = data_r;

endmodule

@@ rtl/core/dsq_lane.sv @@
`timescale 1ns / 1ps

module dsq_lane
  import dsq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lane_ctl_t                        ctl,
  input  logic [7:0]                       item,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
  output logic [7:0]                       front,
  output logic                             full,
  output logic                             empty
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          do_pop;
  logic          do_push;
  logic [CW-1:0] load_pos;
  logic [IW-1:0] load_idx;
  logic [7:0]    cell_data [QUEUE_DEPTH];

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_pop   = ctl.pop & ~empty;
  assign do_push  = ctl.push & (~full | do_pop);
  assign load_pos = do_pop ? (count_r - CW'(1)) : count_r;
  assign load_idx = load_pos[IW-1:0];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [7:0] nbr;
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nbr = DASH;
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end
    dsq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (do_pop),
      .load     (do_push && (load_idx == IW'(i))),
      .item     (item),
      .next_data(nbr),
      .data     (cell_data[i])
    );
  end

  assign count = count_r;
  assign front = cell_data[0];

endmodule

@@ rtl/core/dual_shift_queue_top.sv @@
`timescale 1ns / 1ps
// the result of a request is registered and shows in the cycle after it is accepted
// throughput: one request per cycle; in_tready follows a free or draining output register
// each queue is a row of slot cells that shift toward the front together on a pop
// reset (rst_n low, synchronous): both queues empty, every slot reads dash, no result pending

module dual_shift_queue_top
  import dsq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // item
  input  logic [3:0]  in_tuser,   // operation[2:0], queue_select[3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // item_out, length_first, length_second, front_first,
                                  // front_second, zero fill
  output logic [3:0]  out_tuser   // item_valid, status[2:1], served_queue
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [7:0]    item_out_r;
  logic [7:0]    item_out_nxt;
  logic          item_valid_r;
  logic          item_valid_nxt;
  logic [1:0]    status_r;
  logic [1:0]    status_nxt;
  logic          served_r;
  logic          served_nxt;

  logic          accept;
  op_t           op;
  logic          sel;
  logic          is_enq;
  logic          is_deq;
  logic          is_ovwr;
  logic          known_op;
  lane_ctl_t     ctl_first;
  lane_ctl_t     ctl_second;
  logic [CW-1:0] count_first;
  logic [CW-1:0] count_second;
  logic [7:0]    front_first;
  logic [7:0]    front_second;
  logic          full_first;
  logic          full_second;
  logic          empty_first;
  logic          empty_second;
  logic          full_sel;
  logic          empty_sel;
  logic [7:0]    front_sel;
  logic [CW+4:0] len_first_ext;
  logic [CW+4:0] len_second_ext;

  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;
  assign op        = op_t'(in_tuser[2:0]);

  always_comb begin
    is_enq   = 1'b0;
    is_deq   = 1'b0;
    is_ovwr  = 1'b0;
    known_op = 1'b1;
    sel      = in_tuser[3];
    case (op)
      OP_ENQ: begin
        is_enq = 1'b1;
      end
      OP_ENQ_OVWR: begin
        is_ovwr = 1'b1;
      end
      OP_DEQ: begin
        is_deq = 1'b1;
      end
      OP_BAL_ENQ: begin
        is_enq = 1'b1;
        sel    = ~(count_second > count_first);
      end
      OP_BAL_DEQ: begin
        is_deq = 1'b1;
        sel    = ~(count_second < count_first);
      end
      default: begin
        known_op = 1'b0;
        sel      = 1'b0;
      end
    endcase
  end

  assign full_sel  = sel ? full_second  : full_first;
  assign empty_sel = sel ? empty_second : empty_first;
  assign front_sel = sel ? front_second : front_first;

  always_comb begin
    ctl_first  = '0;
    ctl_second = '0;
    if (accept) begin
      if (sel) begin
        ctl_second.push = is_enq | is_ovwr;
        ctl_second.pop  = is_deq | (is_ovwr & full_second);
      end else begin
        ctl_first.push = is_enq | is_ovwr;
        ctl_first.pop  = is_deq | (is_ovwr & full_first);
      end
    end
  end

  dsq_lane #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_lane_first (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl_first),
    .item (in_tdata),
    .count(count_first),
    .front(front_first),
    .full (full_first),
    .empty(empty_first)
  );

  dsq_lane #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_lane_second (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl_second),
    .item (in_tdata),
    .count(count_second),
    .front(front_second),
    .full (full_second),
    .empty(empty_second)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    item_out_nxt   = item_out_r;
    item_valid_nxt = item_valid_r;
    status_nxt     = status_r;
    served_nxt     = served_r;
    if (accept) begin
      out_valid_nxt  = 1'b1;
      item_valid_nxt = is_deq & ~empty_sel;
      item_out_nxt   = (is_deq & ~empty_sel) ? front_sel : DASH;
      served_nxt     = known_op & sel;
      status_nxt     = ST_OK;
      if (is_enq && full_sel) begin
        status_nxt = ST_FULL;
      end else if (is_deq && empty_sel) begin
        status_nxt = ST_EMPTY;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_out_r   <= item_out_nxt;
    item_valid_r <= item_valid_nxt;
    status_r     <= status_nxt;
    served_r     <= served_nxt;
  end

  // state only moves on an accepted request, so the live queue view matches the held result
  assign len_first_ext  = {5'd0, count_first};
  assign len_second_ext = {5'd0, count_second};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, front_second, front_first, len_second_ext[4:0],
                       len_first_ext[4:0], item_out_r};
  assign out_tuser  = {served_r, status_r, item_valid_r};

endmodule

@@ rtl/core/dsq_checker.sv @@
`timescale 1ns / 1ps

module dsq_checker
  import dsq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [3:0]  out_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_no_take_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken while result stalled");

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == ST_OK)
    else $error("dequeued byte with error status");

  a_dash: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[7:0] == DASH)
    else $error("item_out not dash without dequeue");

endmodule

bind dual_shift_queue_top dsq_checker u_dsq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
